// ===== rtl/longest_remaining_time_scheduler_unit_assert.svh =====
// assertion macros shared by the scheduler modules
// each expects clk and rst_n in the enclosing module
`ifndef LONGEST_REMAINING_TIME_SCHEDULER_UNIT_ASSERT_SVH
`define LONGEST_REMAINING_TIME_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define LRTS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent at one edge implies consequent at the next
`define LRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LRTS_ASSERT_ALWAYS(lbl, cond, msg)
`define LRTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/lrts_pkg.sv =====
package lrts_pkg;

  localparam int MAX_JOBS      = 8;
  localparam int TIME_BITS     = 16;
  localparam int SLOT_BITS     = $clog2(MAX_JOBS);
  localparam int KIND_BITS     = 2;
  localparam int IN_DATA_BITS  = (SLOT_BITS + 2 * TIME_BITS + 7) / 8 * 8;
  localparam int OUT_DATA_BITS = (SLOT_BITS + TIME_BITS + 2 + 7) / 8 * 8;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - SLOT_BITS - TIME_BITS - 2;

  localparam logic [KIND_BITS-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic                 load;
    logic                 clear;
    logic                 scan_begin;
    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 commit;
  } lrts_cmd_t;

  typedef struct packed {
    logic out_busy;
  } lrts_sts_t;

endpackage

// ===== rtl/lrts_datapath.sv =====
`include "longest_remaining_time_scheduler_unit_assert.svh"

module lrts_datapath
  import lrts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  lrts_cmd_t                cmd,
  output lrts_sts_t                sts,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic                     out_tuser
);

  logic [SLOT_BITS-1:0] ld_slot;
  logic [TIME_BITS-1:0] ld_arr;
  logic [TIME_BITS-1:0] ld_burst;

  assign ld_slot  = in_tdata[SLOT_BITS-1:0];
  assign ld_arr   = in_tdata[SLOT_BITS +: TIME_BITS];
  assign ld_burst = in_tdata[SLOT_BITS+TIME_BITS +: TIME_BITS];

  // job tables
  logic [TIME_BITS-1:0] arr_mem [MAX_JOBS];
  logic [TIME_BITS-1:0] rem_mem [MAX_JOBS];

  logic [MAX_JOBS-1:0]  loaded_r, loaded_nxt;
  logic [MAX_JOBS-1:0]  arrived_r, arrived_nxt;
  logic [MAX_JOBS-1:0]  finished_r, finished_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;

  logic                 rd_vld_r;
  logic [SLOT_BITS-1:0] rd_idx_r;
  logic [TIME_BITS-1:0] rd_arr_r;
  logic [TIME_BITS-1:0] rd_rem_r;

  logic                 best_vld_r, best_vld_nxt;
  logic [SLOT_BITS-1:0] best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0] best_rem_r, best_rem_nxt;
  logic [TIME_BITS-1:0] best_arr_r, best_arr_nxt;

  logic                 out_valid_r;
  logic [SLOT_BITS-1:0] out_job_r;
  logic [TIME_BITS-1:0] out_time_r;
  logic                 out_idle_r;
  logic                 out_jfin_r;
  logic                 out_afin_r;

  logic [TIME_BITS-1:0] rem_dec;
  logic                 cand_arrived;
  logic                 cand_elig;
  logic                 cand_better;
  logic                 all_fin;
  logic                 rem_wr_en;
  logic [SLOT_BITS-1:0] rem_wr_addr;
  logic [TIME_BITS-1:0] rem_wr_data;

  assign rem_dec = best_rem_r - TIME_BITS'(1);

  assign cand_arrived = loaded_r[rd_idx_r] && (arrived_r[rd_idx_r] || (rd_arr_r <= time_r));
  assign cand_elig    = rd_vld_r && cand_arrived && !finished_r[rd_idx_r];
  assign cand_better  = !best_vld_r || (rd_rem_r > best_rem_r) ||
                        ((rd_rem_r == best_rem_r) && (rd_arr_r < best_arr_r));

  always_comb begin
    loaded_nxt   = loaded_r;
    arrived_nxt  = arrived_r;
    finished_nxt = finished_r;
    time_nxt     = time_r;
    best_vld_nxt = best_vld_r;
    best_idx_nxt = best_idx_r;
    best_rem_nxt = best_rem_r;
    best_arr_nxt = best_arr_r;
    if (cmd.clear) begin
      loaded_nxt   = '0;
      arrived_nxt  = '0;
      finished_nxt = '0;
      time_nxt     = '0;
    end
    if (cmd.load) begin
      loaded_nxt[ld_slot]   = 1'b1;
      arrived_nxt[ld_slot]  = 1'b0;
      finished_nxt[ld_slot] = (ld_burst == '0);
    end
    if (cmd.scan_begin) begin
      best_vld_nxt = 1'b0;
    end
    // compare stage on the registered table read
    if (rd_vld_r && cand_arrived) begin
      arrived_nxt[rd_idx_r] = 1'b1;
    end
    if (cand_elig && cand_better) begin
      best_vld_nxt = 1'b1;
      best_idx_nxt = rd_idx_r;
      best_rem_nxt = rd_rem_r;
      best_arr_nxt = rd_arr_r;
    end
    if (cmd.commit) begin
      if (best_vld_r && (rem_dec == '0)) begin
        finished_nxt[best_idx_r] = 1'b1;
      end
      if (time_r != {TIME_BITS{1'b1}}) begin
        time_nxt = time_r + TIME_BITS'(1);
      end
    end
  end

  assign all_fin = ((loaded_r & ~finished_nxt) == '0);

  always_comb begin
    rem_wr_en   = 1'b0;
    rem_wr_addr = ld_slot;
    rem_wr_data = ld_burst;
    if (cmd.load) begin
      rem_wr_en = 1'b1;
    end else if (cmd.commit && best_vld_r) begin
      rem_wr_en   = 1'b1;
      rem_wr_addr = best_idx_r;
      rem_wr_data = rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arr_mem[ld_slot] <= ld_arr;
    end
    if (rem_wr_en) begin
      rem_mem[rem_wr_addr] <= rem_wr_data;
    end
    if (cmd.rd_en) begin
      rd_arr_r <= arr_mem[cmd.rd_addr];
      rd_rem_r <= rem_mem[cmd.rd_addr];
    end
    rd_idx_r <= cmd.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r   <= '0;
      arrived_r  <= '0;
      finished_r <= '0;
      time_r     <= '0;
      rd_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      loaded_r   <= loaded_nxt;
      arrived_r  <= arrived_nxt;
      finished_r <= finished_nxt;
      time_r     <= time_nxt;
      rd_vld_r   <= cmd.rd_en;
      best_vld_r <= best_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    best_rem_r <= best_rem_nxt;
    best_arr_r <= best_arr_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_job_r  <= best_vld_r ? best_idx_r : '0;
      out_time_r <= time_r;
      out_idle_r <= !best_vld_r;
      out_jfin_r <= best_vld_r && (rem_dec == '0);
      out_afin_r <= all_fin;
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {{OUT_PAD_BITS{1'b0}}, out_afin_r, out_jfin_r, out_time_r, out_job_r};
  assign out_tuser    = out_idle_r;

  `LRTS_ASSERT_ALWAYS(a_fin_loaded, (finished_r & ~loaded_r) == '0, "finished slot not loaded")
  `LRTS_ASSERT_ALWAYS(a_arr_loaded, (arrived_r & ~loaded_r) == '0, "arrived slot not loaded")
  `LRTS_ASSERT_ALWAYS(a_best_live, !(cmd.commit && best_vld_r && best_rem_r == '0),
                      "chosen job has no remaining time")

endmodule

// ===== rtl/lrts_ctrl.sv =====
`include "longest_remaining_time_scheduler_unit_assert.svh"

module lrts_ctrl
  import lrts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [KIND_BITS-1:0] in_tuser,
  input  lrts_sts_t            sts,
  output lrts_cmd_t            cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [SLOT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign cmd.load       = accept && (in_tuser == KIND_LOAD);
  assign cmd.clear      = accept && (in_tuser == KIND_CLEAR);
  assign cmd.scan_begin = accept && (in_tuser == KIND_TICK);
  assign cmd.rd_en      = (state_r == ST_SCAN);
  assign cmd.rd_addr    = cnt_r;
  assign cmd.commit     = (state_r == ST_FIN) && !sts.out_busy;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.scan_begin) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + SLOT_BITS'(1);
        if (cnt_r == SLOT_BITS'(MAX_JOBS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last table read still in the compare stage
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `LRTS_ASSERT_NEXT(a_tick_scan, cmd.scan_begin, state_r == ST_SCAN && cnt_r == '0,
                    "tick beat did not start a scan")
  `LRTS_ASSERT_NEXT(a_fin_exit, cmd.commit, state_r == ST_IDLE, "commit did not return to idle")
  `LRTS_ASSERT_ALWAYS(a_wr_excl, !(cmd.commit && (cmd.load || cmd.clear)),
                      "table update during commit")

endmodule

// ===== rtl/longest_remaining_time_scheduler_unit.sv =====
// tick beat: MAX_JOBS slot reads through the shared comparator, one drain, then a commit that waits
// while the output is busy and writes back; the result is then registered and the next beat is taken
// load, clear and unused-kind beats are taken in idle without leaving it and give no result
// a result waits in the output register while the scheduler keeps working; the next commit waits until it is taken
// synchronous active-low reset empties the job masks, zeroes the time, drops any result
module longest_remaining_time_scheduler_unit
  import lrts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // slot[2:0], arrival_time[18:3], burst_length[34:19], zero pad
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // kind[1:0]
  input  logic [KIND_BITS-1:0]     in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // job_id[2:0], tick_time[18:3], job_finished[19], all_finished[20], zero pad
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // idle[0]
  output logic                     out_tuser
);

  lrts_cmd_t cmd;
  lrts_sts_t sts;

  lrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrts_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
